/* sv/irptx_pkg.sv */
// ----------------------------------------------------------------------------
// irptx_pkg
// Shared types and constants for the IR pulse-width transmitter.
// ----------------------------------------------------------------------------
package irptx_pkg;

    localparam int BIT_COUNT   = 16;
    localparam int TICK_W      = 16;
    localparam int WORD_W      = 16;
    localparam int LEVEL_W     = 12;
    localparam int CHUNK_W     = 6;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(2 * BIT_COUNT + 1);

    localparam logic [TICK_W-1:0] DEF_HDR_MARK  = TICK_W'(2400);
    localparam logic [TICK_W-1:0] DEF_HDR_SPACE = TICK_W'(600);
    localparam logic [TICK_W-1:0] DEF_ONE_MARK  = TICK_W'(1200);
    localparam logic [TICK_W-1:0] DEF_ZERO_MARK = TICK_W'(600);
    localparam logic [TICK_W-1:0] DEF_BIT_SPACE = TICK_W'(600);

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HDR_MARK  = 3'd0,
        REG_HDR_SPACE = 3'd1,
        REG_ONE_MARK  = 3'd2,
        REG_ZERO_MARK = 3'd3,
        REG_BIT_SPACE = 3'd4
    } cfg_reg_idx_t;

    // Request codes on the input channel
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    typedef struct packed {
        logic [TICK_W-1:0] hdr_mark;
        logic [TICK_W-1:0] hdr_space;
        logic [TICK_W-1:0] one_mark;
        logic [TICK_W-1:0] zero_mark;
        logic [TICK_W-1:0] bit_space;
    } timing_cfg_t;

    typedef struct packed {
        logic               carrier_on;
        logic [LEVEL_W-1:0] carrier_level;
        logic               busy_res;
        logic               done_res;
    } result_t;

endpackage

/* sv/irptx_cfg_regs.sv */
// ----------------------------------------------------------------------------
// irptx_cfg_regs
// Chunk duration registers, written through the configuration port.
// ----------------------------------------------------------------------------
module irptx_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [irptx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [irptx_pkg::TICK_W-1:0]     cfg_data,
    output irptx_pkg::timing_cfg_t           timing
);
    import irptx_pkg::*;

    timing_cfg_t timing_reg;

    assign cfg_ready = 1'b1;
    assign timing    = timing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.hdr_mark  <= DEF_HDR_MARK;
            timing_reg.hdr_space <= DEF_HDR_SPACE;
            timing_reg.one_mark  <= DEF_ONE_MARK;
            timing_reg.zero_mark <= DEF_ZERO_MARK;
            timing_reg.bit_space <= DEF_BIT_SPACE;
        end else if (cfg_valid) begin
            // drop writes to unmapped indexes
            unique case (cfg_index)
                REG_HDR_MARK:  timing_reg.hdr_mark  <= cfg_data;
                REG_HDR_SPACE: timing_reg.hdr_space <= cfg_data;
                REG_ONE_MARK:  timing_reg.one_mark  <= cfg_data;
                REG_ZERO_MARK: timing_reg.zero_mark <= cfg_data;
                REG_BIT_SPACE: timing_reg.bit_space <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* sv/irptx_sequencer.sv */
// ----------------------------------------------------------------------------
// irptx_sequencer
// Frame state: chunk index, tick countdown, data shifter and amplitude.
// ----------------------------------------------------------------------------
module irptx_sequencer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic                            req_type,
    input  logic [irptx_pkg::WORD_W-1:0]    data_word,
    input  logic [irptx_pkg::LEVEL_W-1:0]   dac_level,
    input  irptx_pkg::timing_cfg_t          timing,
    output irptx_pkg::result_t              result_next
);
    import irptx_pkg::*;

    logic                active_reg,  active_next;
    logic [CHUNK_W-1:0]  chunk_reg,   chunk_next;
    logic [TICK_W-1:0]   ticks_reg,   ticks_next;
    logic [WORD_W-1:0]   shift_reg,   shift_next;
    logic [LEVEL_W-1:0]  amp_reg,     amp_next;
    logic                mark_reg,    mark_next;

    logic [CHUNK_W-1:0]  ld_chunk;
    logic [WORD_W-1:0]   ld_shift_in;
    logic                ld_mark;
    logic [TICK_W-1:0]   ld_ticks;
    logic [WORD_W-1:0]   ld_shift_out;

    // Chunk loader: header mark, header space, then mark/space per bit
    always_comb begin
        ld_shift_out = ld_shift_in;
        if (ld_chunk == '0) begin
            ld_mark  = 1'b1;
            ld_ticks = timing.hdr_mark;
        end else if (ld_chunk == CHUNK_W'(1)) begin
            ld_mark  = 1'b0;
            ld_ticks = timing.hdr_space;
        end else if (!ld_chunk[0]) begin
            ld_mark      = 1'b1;
            ld_ticks     = ld_shift_in[WORD_W-1] ? timing.one_mark : timing.zero_mark;
            ld_shift_out = {ld_shift_in[WORD_W-2:0], 1'b0};
        end else begin
            ld_mark  = 1'b0;
            ld_ticks = timing.bit_space;
        end
    end

    always_comb begin
        active_next = active_reg;
        chunk_next  = chunk_reg;
        ticks_next  = ticks_reg;
        shift_next  = shift_reg;
        amp_next    = amp_reg;
        mark_next   = mark_reg;
        ld_chunk    = '0;
        ld_shift_in = data_word;
        result_next.carrier_on = 1'b0;
        result_next.done_res   = 1'b0;

        if (req_type == REQ_START) begin
            // restart from the header mark; the start beat uses no tick
            amp_next    = dac_level;
            active_next = 1'b1;
            chunk_next  = '0;
            mark_next   = ld_mark;
            ticks_next  = ld_ticks;
            shift_next  = ld_shift_out;
            result_next.carrier_on = 1'b1;
        end else if (active_reg) begin
            result_next.carrier_on = mark_reg;
            ld_chunk    = chunk_reg + CHUNK_W'(1);
            ld_shift_in = shift_reg;
            if (ticks_reg > TICK_W'(1)) begin
                ticks_next = ticks_reg - TICK_W'(1);
            end else if (chunk_reg >= LAST_CHUNK) begin
                active_next = 1'b0;
                mark_next   = 1'b0;
                ticks_next  = '0;
                result_next.done_res = 1'b1;
            end else begin
                chunk_next = ld_chunk;
                mark_next  = ld_mark;
                ticks_next = ld_ticks;
                shift_next = ld_shift_out;
            end
        end

        result_next.carrier_level = amp_next;
        result_next.busy_res      = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            chunk_reg  <= '0;
            ticks_reg  <= '0;
            shift_reg  <= '0;
            amp_reg    <= '0;
            mark_reg   <= 1'b0;
        end else if (accept) begin
            active_reg <= active_next;
            chunk_reg  <= chunk_next;
            ticks_reg  <= ticks_next;
            shift_reg  <= shift_next;
            amp_reg    <= amp_next;
            mark_reg   <= mark_next;
        end
    end

endmodule

/* sv/irptx_out_reg.sv */
// ----------------------------------------------------------------------------
// irptx_out_reg
// Result register with valid/ready toward the result channel.
// ----------------------------------------------------------------------------
module irptx_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  irptx_pkg::result_t  result_next,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output irptx_pkg::result_t  result
);
    import irptx_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // free when empty or when the held beat leaves this cycle
    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign result   = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

endmodule

/* sv/ir_pulse_width_transmitter_top.sv */
// ----------------------------------------------------------------------------
// ir_pulse_width_transmitter_top
// SIRC-style IR frame timer: header mark/space, then MSB-first bit marks
// and spaces, one result beat per tick or start beat.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    req_type, data_word, dac_level
//   m_       out        m_valid / m_ready    carrier_on, carrier_level,
//                                            busy_res, done_res
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One beat per cycle while s_ready is high: a beat updates the frame state and
// loads the result register at the edge it is accepted; the result is valid in the next cycle.
// s_ready drops only while a result is held and m_ready is low.
// Reset (aresetn low, synchronous) idles the frame and restores the default
// durations; cfg_ready is always high.
// ----------------------------------------------------------------------------
module ir_pulse_width_transmitter_top (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_req_type,
    input  logic [irptx_pkg::WORD_W-1:0]     s_data_word,
    input  logic [irptx_pkg::LEVEL_W-1:0]    s_dac_level,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_carrier_on,
    output logic [irptx_pkg::LEVEL_W-1:0]    m_carrier_level,
    output logic                             m_busy_res,
    output logic                             m_done_res,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [irptx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [irptx_pkg::TICK_W-1:0]     cfg_data
);
    import irptx_pkg::*;

    timing_cfg_t timing;
    result_t     result_next;
    result_t     result;
    logic        can_load;
    logic        accept;

    // take a beat whenever the result register can hold its answer
    assign s_ready = can_load;
    assign accept  = s_valid && can_load;

    irptx_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    // frame state advances only on an accepted beat
    irptx_sequencer u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .req_type    (s_req_type),
        .data_word   (s_data_word),
        .dac_level   (s_dac_level),
        .timing      (timing),
        .result_next (result_next)
    );

    // hold the result until the downstream side takes it
    irptx_out_reg u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (accept),
        .result_next (result_next),
        .can_load    (can_load),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .result      (result)
    );

    assign m_carrier_on    = result.carrier_on;
    assign m_carrier_level = result.carrier_level;
    assign m_busy_res      = result.busy_res;
    assign m_done_res      = result.done_res;

endmodule
